// ----- hdl/lpd_pkg.sv -----
// ----------------------------------------------------------------------------
// lpd_pkg
// Beat types, field offsets and codes shared by the lidar packet deframer.
// ----------------------------------------------------------------------------
package lpd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       packet_start;
  } in_beat_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  block_index;
    logic [15:0] block_id;
    logic [15:0] azimuth;
    logic [4:0]  laser_index;
    logic [15:0] distance;
    logic [7:0]  intensity;
    logic [31:0] gps_timestamp;
    logic [7:0]  status_type;
    logic [7:0]  status_value;
  } result_t;

  localparam logic KIND_POINT   = 1'b0;
  localparam logic KIND_TRAILER = 1'b1;

  // block header byte offsets
  localparam int HDR_ID_LO  = 0;
  localparam int HDR_ID_HI  = 1;
  localparam int HDR_AZ_LO  = 2;
  localparam int HDR_AZ_HI  = 3;
  localparam int HDR_BYTES  = 4;
  localparam int RET_BYTES  = 3;

  // trailer byte offsets
  localparam int TRL_TS0         = 0;
  localparam int TRL_TS1         = 1;
  localparam int TRL_TS2         = 2;
  localparam int TRL_TS3         = 3;
  localparam int TRL_STATUS_TYPE = 4;
  localparam int TRAILER_BYTES   = 6;

  // byte phase within one return
  localparam logic [1:0] PH_DIST_LO   = 2'd0;
  localparam logic [1:0] PH_DIST_HI   = 2'd1;
  localparam logic [1:0] PH_INTENSITY = 2'd2;

endpackage

// ----- hdl/lpd_in_skid.sv -----
// ----------------------------------------------------------------------------
// lpd_in_skid
// Input skid register: holds one beat when the result side cannot take it,
// so the upstream stall comes straight from a flop.
// ----------------------------------------------------------------------------
module lpd_in_skid
  import lpd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  in_beat_t in_data,
  output logic     stall,
  input  logic     drain,
  output logic     src_valid,
  output in_beat_t src_data
);

  logic     skid_valid;
  in_beat_t skid_data;

  assign stall     = skid_valid;
  assign src_valid = skid_valid | in_valid;
  assign src_data  = skid_valid ? skid_data : in_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (drain) begin
        skid_valid <= 1'b0;
      end
    end else if (in_valid && !drain) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid && in_valid && !drain) begin
      skid_data <= in_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    skid_valid && !drain |=> skid_valid && $stable(skid_data))
    else $error("skid beat lost while blocked");

endmodule

// ----- hdl/lpd_decode.sv -----
// ----------------------------------------------------------------------------
// lpd_decode
// Byte position tracking and field assembly. Builds the result of the
// current beat combinationally and advances the framing state on fire.
// ----------------------------------------------------------------------------
module lpd_decode
  import lpd_pkg::*;
#(
  parameter int PACKET_BYTES      = 1206,
  parameter int BLOCK_BYTES       = 100,
  parameter int BLOCKS_PER_PACKET = 12,
  parameter int LASERS_PER_BLOCK  = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     fire,
  input  in_beat_t beat,
  output logic     hit,
  output result_t  res
);

  localparam int POS_W         = $clog2(PACKET_BYTES);
  localparam int JW            = $clog2(BLOCK_BYTES);
  localparam int BLOCK_AREA    = BLOCKS_PER_PACKET * BLOCK_BYTES;
  localparam int TRAILER_START = PACKET_BYTES - TRAILER_BYTES;
  localparam int BLOCK_END     = (BLOCK_AREA < TRAILER_START) ? BLOCK_AREA : TRAILER_START;
  localparam int RET_END       = HDR_BYTES + RET_BYTES * LASERS_PER_BLOCK;

  logic [POS_W-1:0] pos, pos_c, pos_next;
  logic [JW-1:0]    j, j_c, j_next;
  logic [3:0]       blk, blk_c, blk_next;
  logic [4:0]       las, las_c, las_next;
  logic [1:0]       phase, phase_c, phase_next;
  logic [15:0]      id_hold, id_next;
  logic [15:0]      az_hold, az_next;
  logic [15:0]      dist_hold, dist_next;
  logic [31:0]      ts_hold, ts_next;
  logic [7:0]       st_hold, st_next;
  logic [7:0]       b;

  assign b = beat.data_byte;

  always_comb begin
    pos_c   = beat.packet_start ? '0 : pos;
    j_c     = beat.packet_start ? '0 : j;
    blk_c   = beat.packet_start ? '0 : blk;
    las_c   = beat.packet_start ? '0 : las;
    phase_c = beat.packet_start ? PH_DIST_LO : phase;

    j_next     = j_c;
    blk_next   = blk_c;
    las_next   = las_c;
    phase_next = phase_c;
    id_next    = id_hold;
    az_next    = az_hold;
    dist_next  = dist_hold;
    ts_next    = ts_hold;
    st_next    = st_hold;
    hit        = 1'b0;
    res        = '0;

    if (pos_c < POS_W'(BLOCK_END)) begin
      if (j_c == JW'(HDR_ID_LO)) begin
        id_next = {8'h00, b};
      end else if (j_c == JW'(HDR_ID_HI)) begin
        id_next = {b, id_hold[7:0]};
      end else if (j_c == JW'(HDR_AZ_LO)) begin
        az_next = {8'h00, b};
      end else if (j_c == JW'(HDR_AZ_HI)) begin
        az_next = {b, az_hold[7:0]};
      end else if (32'(j_c) < RET_END) begin
        phase_next = (phase_c == PH_INTENSITY) ? PH_DIST_LO : phase_c + 2'd1;
        case (phase_c)
          PH_DIST_LO: begin
            dist_next = {8'h00, b};
          end
          PH_DIST_HI: begin
            dist_next = {b, dist_hold[7:0]};
          end
          PH_INTENSITY: begin
            hit             = 1'b1;
            res.kind        = KIND_POINT;
            res.block_index = blk_c;
            res.block_id    = id_hold;
            res.azimuth     = az_hold;
            res.laser_index = las_c;
            res.distance    = dist_hold;
            res.intensity   = b;
            dist_next       = '0;
            las_next        = las_c + 5'd1;
          end
          default: begin
          end
        endcase
      end
      if (j_c == JW'(BLOCK_BYTES - 1)) begin
        j_next     = '0;
        blk_next   = blk_c + 4'd1;
        las_next   = '0;
        id_next    = '0;
        az_next    = '0;
        phase_next = PH_DIST_LO;
      end else begin
        j_next = j_c + JW'(1);
      end
    end else if (pos_c >= POS_W'(TRAILER_START)) begin
      if (pos_c == POS_W'(TRAILER_START + TRL_TS0)) begin
        ts_next = {24'h000000, b};
      end else if (pos_c == POS_W'(TRAILER_START + TRL_TS1)) begin
        ts_next[15:8] = b;
      end else if (pos_c == POS_W'(TRAILER_START + TRL_TS2)) begin
        ts_next[23:16] = b;
      end else if (pos_c == POS_W'(TRAILER_START + TRL_TS3)) begin
        ts_next[31:24] = b;
      end else if (pos_c == POS_W'(TRAILER_START + TRL_STATUS_TYPE)) begin
        st_next = b;
      end else begin
        hit               = 1'b1;
        res.kind          = KIND_TRAILER;
        res.gps_timestamp = ts_hold;
        res.status_type   = st_hold;
        res.status_value  = b;
      end
    end

    if (pos_c == POS_W'(PACKET_BYTES - 1)) begin
      pos_next   = '0;
      j_next     = '0;
      blk_next   = '0;
      las_next   = '0;
      phase_next = PH_DIST_LO;
    end else begin
      pos_next = pos_c + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      j     <= '0;
      blk   <= '0;
      las   <= '0;
      phase <= PH_DIST_LO;
    end else if (fire) begin
      pos   <= pos_next;
      j     <= j_next;
      blk   <= blk_next;
      las   <= las_next;
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      id_hold   <= id_next;
      az_hold   <= az_next;
      dist_hold <= dist_next;
      ts_hold   <= ts_next;
      st_hold   <= st_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    phase == PH_DIST_LO || phase == PH_DIST_HI || phase == PH_INTENSITY)
    else $error("return phase out of range");

  assert property (@(posedge clk) disable iff (rst)
    fire && hit && res.kind == KIND_TRAILER |-> pos_c == POS_W'(PACKET_BYTES - 1))
    else $error("trailer result away from last packet byte");

endmodule

// ----- hdl/lidar_packet_deframer.sv -----
// ----------------------------------------------------------------------------
// lidar_packet_deframer
// Splits a lidar firing-data packet, one byte per beat, into point results
// (one per return) and one trailer result per packet.
// ----------------------------------------------------------------------------
// Takes one byte per clock, while the result side does not stall, with no
// gaps of its own making. With the result side free, the result of an
// accepted byte, if any, is in the output register from the next cycle.
// The byte position counter and the field holds advance by one byte per
// cycle while bytes are taken, and that update loop sets the rate. An input
// skid register takes one more byte while the result side stalls; the byte
// side then stalls until the held byte has moved on after the result side
// frees up. packet_start on a byte realigns framing to the packet start; a
// packet also rolls over to the next on its own after its final byte.
// ----------------------------------------------------------------------------
module lidar_packet_deframer
  import lpd_pkg::*;
#(
  parameter int PACKET_BYTES      = 1206,
  parameter int BLOCK_BYTES       = 100,
  parameter int BLOCKS_PER_PACKET = 12,
  parameter int LASERS_PER_BLOCK  = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     byte_valid,
  output logic     byte_stall,
  input  in_beat_t byte_data,
  output logic     result_valid,
  input  logic     result_stall,
  output result_t  result_data
);

  logic     out_free;
  logic     src_valid;
  in_beat_t src_data;
  logic     fire;
  logic     hit;
  result_t  res;

  assign out_free = !result_valid || !result_stall;
  assign fire     = src_valid && out_free;

  lpd_in_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (byte_valid),
    .in_data   (byte_data),
    .stall     (byte_stall),
    .drain     (out_free),
    .src_valid (src_valid),
    .src_data  (src_data)
  );

  lpd_decode #(
    .PACKET_BYTES      (PACKET_BYTES),
    .BLOCK_BYTES       (BLOCK_BYTES),
    .BLOCKS_PER_PACKET (BLOCKS_PER_PACKET),
    .LASERS_PER_BLOCK  (LASERS_PER_BLOCK)
  ) u_decode (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .beat (src_data),
    .hit  (hit),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= hit;
    end else if (out_free) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && hit) begin
      result_data <= res;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    byte_stall && !result_stall |=> !byte_stall)
    else $error("skid beat not drained with result side free");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.kind == KIND_POINT
      |-> 32'(result_data.laser_index) < LASERS_PER_BLOCK)
    else $error("laser index beyond block");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.kind == KIND_POINT
      |-> 32'(result_data.block_index) < BLOCKS_PER_PACKET)
    else $error("block index beyond packet");

endmodule
